// ===== rtl/core/cbaw_pkg.sv =====
// Shared types and constants of the cone-beam axial weight generator.
package cbaw_pkg;

	localparam int MaxRowsDef = 4096;
	localparam int MaxRunDef  = 64;
	localparam int CfgIdxW    = 3;
	localparam int CfgDataW   = 32;
	localparam int DivSteps   = 64;
	localparam int SqrtSteps  = 32;

	typedef struct packed {
		logic signed [31:0] voxel_u;
		logic signed [31:0] voxel_w;
	} vox_t;

	typedef struct packed {
		logic [11:0] first_row;
		logic [6:0]  row_count;
		logic [11:0] row_index;
		logic [31:0] weight;
		logic        empty_res;
		logic        last;
	} res_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_SOURCE_U   = 3'd0,
		REG_SDD        = 3'd1,
		REG_W_FIRST    = 3'd2,
		REG_PITCH      = 3'd3,
		REG_ROWS       = 3'd4,
		REG_THICK      = 3'd5,
		REG_QUANT_INV  = 3'd6,
		REG_QUANT_EN   = 3'd7
	} cfg_reg_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DIV_M,
		ST_MUL_W,
		ST_MUL_MW,
		ST_MW,
		ST_EDGE,
		ST_DIV_F,
		ST_DIV_S,
		ST_CLAMP,
		ST_OBL_A,
		ST_OBL_B,
		ST_OBL_SUM,
		ST_SQRT,
		ST_DIV_OBL,
		ST_ROW_WD,
		ST_ROW_LEN,
		ST_ROW_MLF,
		ST_ROW_DIV,
		ST_DIV_WT,
		ST_ROW_Q,
		ST_ROW_QD,
		ST_OUT,
		ST_EMPTY
	} state_t;

endpackage

// ===== rtl/core/cone_beam_axial_weight_gen_unit.sv =====
// Top level of the cone-beam axial weight generator: sequencer and shared datapath.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------
//  vox     | in        | vox_valid / vox_stall | cbaw_pkg::vox_t (voxel_u, voxel_w)
//  res     | out       | res_valid / res_stall | cbaw_pkg::res_t (one row weight)
//  cfg     | in        | cfg_we                | cfg_index, cfg_data
//
// One voxel runs a setup phase and then one pass per touched row, with a quantizing
// step when quantizing is on (a result can wait under res_stall); an empty run goes
// straight to its result when the source sits at the voxel, else after the edge rows.
// Most work runs through the single 1-bit-per-cycle 64-step divider, which serves
// the magnification, both edge rows, the obliquity and every row weight, plus a
// 32-step square root unit and one shared 33x33 multiplier.
// vox_stall is high from the accepting transfer until the last result transfer.
// arst_n clears the sequencer and the step counters; config regs reset to defaults.
module cone_beam_axial_weight_gen_unit #(
	parameter int MAX_ROWS = cbaw_pkg::MaxRowsDef,
	parameter int MAX_RUN  = cbaw_pkg::MaxRunDef
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [cbaw_pkg::CfgIdxW-1:0]     cfg_index,
	input  logic [cbaw_pkg::CfgDataW-1:0]    cfg_data,
	input  logic                             vox_valid,
	output logic                             vox_stall,
	input  cbaw_pkg::vox_t                   vox,
	output logic                             res_valid,
	input  logic                             res_stall,
	output cbaw_pkg::res_t                   res
);

	// ---------------- configuration registers ----------------
	logic signed [31:0] source_u_q, sdd_q, w_first_q;
	logic [30:0]        pitch_q, thick_q;
	logic [12:0]        rows_q;
	logic [31:0]        qinv_q;
	logic               quant_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_u_q <= '0;
			sdd_q      <= 32'sd65536;
			w_first_q  <= '0;
			pitch_q    <= 31'd65536;
			rows_q     <= 13'd1;
			thick_q    <= 31'd65536;
			qinv_q     <= 32'd65536;
			quant_q    <= 1'b1;
		end else if (cfg_we) begin
			unique case (cbaw_pkg::cfg_reg_t'(cfg_index))
				cbaw_pkg::REG_SOURCE_U:  source_u_q <= $signed(cfg_data);
				cbaw_pkg::REG_SDD:       sdd_q      <= $signed(cfg_data);
				cbaw_pkg::REG_W_FIRST:   w_first_q  <= $signed(cfg_data);
				cbaw_pkg::REG_PITCH:     pitch_q    <= cfg_data[30:0];
				cbaw_pkg::REG_ROWS:      rows_q     <= cfg_data[12:0];
				cbaw_pkg::REG_THICK:     thick_q    <= cfg_data[30:0];
				cbaw_pkg::REG_QUANT_INV: qinv_q     <= cfg_data;
				cbaw_pkg::REG_QUANT_EN:  quant_q    <= cfg_data[0];
			endcase
		end
	end

	// effective pitch and row limit
	logic [30:0]        p_eff;
	logic signed [31:0] p_s;
	logic [16:0]        rows_eff;
	logic signed [17:0] rows_m1;
	logic signed [32:0] centre;
	assign p_eff    = (pitch_q == '0) ? 31'd1 : pitch_q;
	assign p_s      = $signed({1'b0, p_eff});
	assign rows_eff = (17'(rows_q) > 17'(MAX_ROWS)) ? 17'(MAX_ROWS) : 17'(rows_q);
	assign rows_m1  = $signed({1'b0, rows_eff}) - 18'sd1;
	assign centre   = 33'(w_first_q) + 33'($signed({1'b0, p_eff[30:1]}));

	// ---------------- sequencer ----------------
	cbaw_pkg::state_t state_q, state_d;

	// working registers
	logic signed [32:0] du_q;
	logic signed [31:0] vw_q, m_q;
	logic signed [47:0] wp_q, mw_q;
	logic signed [52:0] first_q, stop_q;
	logic [15:0]        first_row_q, row_q;
	logic [6:0]         count_q, k_q;
	logic [30:0]        a_q, b_q, len_q;
	logic [63:0]        sq_q;
	logic [31:0]        f_q, wt_q;

	// shared multiplier, result registered
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_p_q;
	always_ff @(posedge clk) begin
		mul_p_q <= mul_a * mul_b;
	end

	// shared divider: unsigned, one quotient bit per cycle
	logic        div_start, div_neg_d, div_neg_q, div_done;
	logic [63:0] div_num, div_quo_q;
	logic [32:0] div_den, div_den_q, div_rem_q;
	logic [6:0]  div_cnt_q;
	logic [33:0] div_sh, div_diff;
	logic        div_ge;
	assign div_sh   = {div_rem_q, div_quo_q[63]};
	assign div_diff = div_sh - {1'b0, div_den_q};
	assign div_ge   = div_sh >= {1'b0, div_den_q};
	assign div_done = (div_cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (div_start) begin
			div_cnt_q <= 7'(cbaw_pkg::DivSteps);
		end else if (!div_done) begin
			div_cnt_q <= div_cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			div_quo_q <= div_num;
			div_rem_q <= '0;
			div_den_q <= div_den;
			div_neg_q <= div_neg_d;
		end else if (!div_done) begin
			div_rem_q <= div_ge ? div_diff[32:0] : div_sh[32:0];
			div_quo_q <= {div_quo_q[62:0], div_ge};
		end
	end

	// signed views of the quotient
	logic signed [52:0] div_q53;
	logic signed [31:0] m_sat;
	assign div_q53 = div_neg_q ? -$signed(div_quo_q[52:0]) : $signed(div_quo_q[52:0]);
	always_comb begin
		if (!div_neg_q) begin
			m_sat = (div_quo_q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(div_quo_q[31:0]);
		end else begin
			m_sat = (div_quo_q > 64'h8000_0000) ? 32'sh8000_0000 : -$signed(div_quo_q[31:0]);
		end
	end

	// square root unit, two bits of radicand per cycle
	logic        sqrt_start, sqrt_done;
	logic [63:0] sqrt_n_q;
	logic [35:0] sqrt_rem_q, sqrt_sh, sqrt_trial;
	logic [31:0] sqrt_root_q;
	logic [5:0]  sqrt_cnt_q;
	assign sqrt_sh    = {sqrt_rem_q[33:0], sqrt_n_q[63:62]};
	assign sqrt_trial = {2'b00, sqrt_root_q, 2'b01};
	assign sqrt_done  = (sqrt_cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sqrt_cnt_q <= '0;
		end else if (sqrt_start) begin
			sqrt_cnt_q <= 6'(cbaw_pkg::SqrtSteps);
		end else if (!sqrt_done) begin
			sqrt_cnt_q <= sqrt_cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (sqrt_start) begin
			sqrt_n_q    <= sq_q + mul_p_q[63:0];
			sqrt_rem_q  <= '0;
			sqrt_root_q <= '0;
		end else if (!sqrt_done) begin
			sqrt_n_q <= {sqrt_n_q[61:0], 2'b00};
			if (sqrt_sh >= sqrt_trial) begin
				sqrt_rem_q  <= sqrt_sh - sqrt_trial;
				sqrt_root_q <= {sqrt_root_q[30:0], 1'b1};
			end else begin
				sqrt_rem_q  <= sqrt_sh;
				sqrt_root_q <= {sqrt_root_q[30:0], 1'b0};
			end
		end
	end

	// ---------------- combinational datapath pieces ----------------
	logic signed [32:0] du_in;
	logic [32:0]        du_mag;
	logic [31:0]        sdd_mag;
	assign du_in   = 33'(vox.voxel_u) - 33'(source_u_q);
	assign du_mag  = du_in[32] ? 33'(-du_in) : du_in;
	assign sdd_mag = sdd_q[31] ? 32'(-sdd_q) : sdd_q;

	// edge numerators: 2*base -/+ W + p
	logic signed [48:0] base;
	logic signed [52:0] num_f, num_s, num_sel;
	logic [52:0]        num_mag;
	logic               use_stop;
	assign base     = 49'(mw_q) - 49'(centre);
	assign num_f    = (53'(base) <<< 1) - 53'(wp_q) + 53'(p_s);
	assign num_s    = (53'(base) <<< 1) + 53'(wp_q) + 53'(p_s);
	assign use_stop = (state_q == cbaw_pkg::ST_DIV_F);
	assign num_sel  = use_stop ? num_s : num_f;
	assign num_mag  = num_sel[52] ? 53'(-num_sel) : num_sel;

	// run bounds
	logic signed [52:0] first_c, stop_c;
	logic signed [53:0] count_c;
	assign first_c = first_q[52] ? '0 : first_q;
	assign stop_c  = (stop_q > 53'(rows_m1)) ? 53'(rows_m1) : stop_q;
	assign count_c = 54'(stop_c) - 54'(first_c) + 54'sd1;

	// obliquity operands, scaled together below 2^31
	logic [32:0] a_full;
	logic [31:0] b_full;
	logic [30:0] a_scl, b_scl;
	assign a_full = du_q[32] ? 33'(-du_q) : du_q;
	assign b_full = vw_q[31] ? 32'(-vw_q) : vw_q;
	always_comb begin
		if (a_full[32]) begin
			a_scl = a_full[32:2];
			b_scl = 31'(b_full >> 2);
		end else if (a_full[31] || b_full[31]) begin
			a_scl = a_full[31:1];
			b_scl = b_full[31:1];
		end else begin
			a_scl = a_full[30:0];
			b_scl = b_full[30:0];
		end
	end

	// overlap length of one row
	logic signed [49:0] wd;
	logic signed [50:0] dd;
	logic [51:0]        d2;
	logic signed [48:0] wmp, wpp;
	logic [48:0]        bb;
	logic [51:0]        mx;
	logic signed [53:0] l2;
	logic [52:0]        half;
	logic [30:0]        len_c;
	assign wd   = 50'(centre) + 50'($signed({2'b00, mul_p_q[47:0]}));
	assign dd   = 51'(wd) - 51'(mw_q);
	assign d2   = {(dd[50] ? 51'(-dd) : dd), 1'b0};
	assign wmp  = 49'(wp_q) - 49'(p_s);
	assign wpp  = 49'(wp_q) + 49'(p_s);
	assign bb   = wmp[48] ? 49'(-wmp) : wmp;
	assign mx   = (52'(bb) > d2) ? 52'(bb) : d2;
	assign l2   = 54'(wpp) - $signed({2'b00, mx});
	assign half = (l2 > 54'sd0) ? l2[53:1] : '0;
	assign len_c = (half > 53'(p_eff)) ? p_eff : half[30:0];

	// saturations
	logic [31:0] f_sat, wt_sat;
	logic [32:0] code_sum;
	logic [31:0] code;
	assign f_sat    = (div_quo_q > 64'hFFFF_FFFF) ? '1 : div_quo_q[31:0];
	assign wt_sat   = f_sat;
	assign code_sum = {1'b0, mul_p_q[63:32]} + 33'(mul_p_q[31]);
	assign code     = (code_sum > 33'd255) ? 32'd255 : 32'(code_sum[7:0]);

	logic last_row;
	assign last_row = (k_q == count_q - 7'd1);

	// ---------------- state register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cbaw_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ---------------- next state and unit control ----------------
	always_comb begin
		state_d    = state_q;
		div_start  = 1'b0;
		div_num    = '0;
		div_den    = 33'd1;
		div_neg_d  = 1'b0;
		sqrt_start = 1'b0;
		mul_a      = '0;
		mul_b      = '0;
		vox_stall  = 1'b1;
		res_valid  = 1'b0;
		unique case (state_q)
			cbaw_pkg::ST_IDLE: begin
				vox_stall = 1'b0;
				if (vox_valid) begin
					if (du_in == '0) begin
						state_d = cbaw_pkg::ST_EMPTY;
					end else begin
						div_start = 1'b1;
						div_num   = {16'd0, sdd_mag, 16'd0};
						div_den   = du_mag;
						div_neg_d = sdd_q[31] ^ du_in[32];
						state_d   = cbaw_pkg::ST_DIV_M;
					end
				end
			end
			cbaw_pkg::ST_DIV_M: begin
				if (div_done) state_d = cbaw_pkg::ST_MUL_W;
			end
			cbaw_pkg::ST_MUL_W: begin
				mul_a   = 33'(m_q);
				mul_b   = $signed({2'b00, thick_q});
				state_d = cbaw_pkg::ST_MUL_MW;
			end
			cbaw_pkg::ST_MUL_MW: begin
				mul_a   = 33'(m_q);
				mul_b   = 33'(vw_q);
				state_d = cbaw_pkg::ST_MW;
			end
			cbaw_pkg::ST_MW: begin
				state_d = cbaw_pkg::ST_EDGE;
			end
			cbaw_pkg::ST_EDGE: begin
				div_start = 1'b1;
				div_num   = 64'(num_mag);
				div_den   = {1'b0, p_eff, 1'b0};
				div_neg_d = num_sel[52];
				state_d   = cbaw_pkg::ST_DIV_F;
			end
			cbaw_pkg::ST_DIV_F: begin
				if (div_done) begin
					div_start = 1'b1;
					div_num   = 64'(num_mag);
					div_den   = {1'b0, p_eff, 1'b0};
					div_neg_d = num_sel[52];
					state_d   = cbaw_pkg::ST_DIV_S;
				end
			end
			cbaw_pkg::ST_DIV_S: begin
				if (div_done) state_d = cbaw_pkg::ST_CLAMP;
			end
			cbaw_pkg::ST_CLAMP: begin
				state_d = (count_c <= 54'sd0) ? cbaw_pkg::ST_EMPTY : cbaw_pkg::ST_OBL_A;
			end
			cbaw_pkg::ST_OBL_A: begin
				mul_a   = $signed({2'b00, a_q});
				mul_b   = $signed({2'b00, a_q});
				state_d = (a_q == '0) ? cbaw_pkg::ST_ROW_WD : cbaw_pkg::ST_OBL_B;
			end
			cbaw_pkg::ST_OBL_B: begin
				mul_a   = $signed({2'b00, b_q});
				mul_b   = $signed({2'b00, b_q});
				state_d = cbaw_pkg::ST_OBL_SUM;
			end
			cbaw_pkg::ST_OBL_SUM: begin
				sqrt_start = 1'b1;
				state_d    = cbaw_pkg::ST_SQRT;
			end
			cbaw_pkg::ST_SQRT: begin
				if (sqrt_done) begin
					div_start = 1'b1;
					div_num   = {16'd0, sqrt_root_q, 16'd0};
					div_den   = {2'b00, a_q};
					state_d   = cbaw_pkg::ST_DIV_OBL;
				end
			end
			cbaw_pkg::ST_DIV_OBL: begin
				if (div_done) state_d = cbaw_pkg::ST_ROW_WD;
			end
			cbaw_pkg::ST_ROW_WD: begin
				mul_a   = $signed({17'd0, row_q});
				mul_b   = $signed({2'b00, p_eff});
				state_d = cbaw_pkg::ST_ROW_LEN;
			end
			cbaw_pkg::ST_ROW_LEN: begin
				state_d = cbaw_pkg::ST_ROW_MLF;
			end
			cbaw_pkg::ST_ROW_MLF: begin
				mul_a   = $signed({2'b00, len_q});
				mul_b   = $signed({1'b0, f_q});
				state_d = cbaw_pkg::ST_ROW_DIV;
			end
			cbaw_pkg::ST_ROW_DIV: begin
				div_start = 1'b1;
				div_num   = mul_p_q[63:0];
				div_den   = {2'b00, p_eff};
				state_d   = cbaw_pkg::ST_DIV_WT;
			end
			cbaw_pkg::ST_DIV_WT: begin
				if (div_done) state_d = quant_q ? cbaw_pkg::ST_ROW_Q : cbaw_pkg::ST_OUT;
			end
			cbaw_pkg::ST_ROW_Q: begin
				mul_a   = $signed({1'b0, wt_q});
				mul_b   = $signed({1'b0, qinv_q});
				state_d = cbaw_pkg::ST_ROW_QD;
			end
			cbaw_pkg::ST_ROW_QD: begin
				state_d = cbaw_pkg::ST_OUT;
			end
			cbaw_pkg::ST_OUT: begin
				res_valid = 1'b1;
				if (!res_stall) state_d = last_row ? cbaw_pkg::ST_IDLE : cbaw_pkg::ST_ROW_WD;
			end
			cbaw_pkg::ST_EMPTY: begin
				res_valid = 1'b1;
				if (!res_stall) state_d = cbaw_pkg::ST_IDLE;
			end
			default: state_d = cbaw_pkg::ST_IDLE;
		endcase
	end

	// ---------------- working register loads ----------------
	always_ff @(posedge clk) begin
		case (state_q)
			cbaw_pkg::ST_IDLE: begin
				du_q <= du_in;
				vw_q <= vox.voxel_w;
			end
			cbaw_pkg::ST_DIV_M:   if (div_done) m_q <= m_sat;
			cbaw_pkg::ST_MUL_MW:  wp_q <= mul_p_q[63:16];
			cbaw_pkg::ST_MW:      mw_q <= mul_p_q[63:16];
			cbaw_pkg::ST_DIV_F:   if (div_done) first_q <= div_q53;
			cbaw_pkg::ST_DIV_S:   if (div_done) stop_q <= div_q53;
			cbaw_pkg::ST_CLAMP: begin
				first_row_q <= first_c[15:0];
				row_q       <= first_c[15:0];
				k_q         <= '0;
				count_q     <= (count_c > 54'(MAX_RUN)) ? 7'(MAX_RUN) : count_c[6:0];
				a_q         <= a_scl;
				b_q         <= b_scl;
			end
			cbaw_pkg::ST_OBL_A:   if (a_q == '0) f_q <= '1;
			cbaw_pkg::ST_OBL_B:   sq_q <= mul_p_q[63:0];
			cbaw_pkg::ST_DIV_OBL: if (div_done) f_q <= f_sat;
			cbaw_pkg::ST_ROW_LEN: len_q <= len_c;
			cbaw_pkg::ST_DIV_WT:  if (div_done) wt_q <= wt_sat;
			cbaw_pkg::ST_ROW_QD:  wt_q <= code;
			cbaw_pkg::ST_OUT: begin
				if (!res_stall) begin
					row_q <= row_q + 16'd1;
					k_q   <= k_q + 7'd1;
				end
			end
			default: ;
		endcase
	end

	// ---------------- result payload ----------------
	always_comb begin
		if (state_q == cbaw_pkg::ST_EMPTY) begin
			res           = '0;
			res.empty_res = 1'b1;
			res.last      = 1'b1;
		end else begin
			res.first_row = first_row_q[11:0];
			res.row_count = count_q;
			res.row_index = row_q[11:0];
			res.weight    = wt_q;
			res.empty_res = 1'b0;
			res.last      = last_row;
		end
	end

	// ---------------- assertions ----------------
	a_no_result_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!vox_stall |-> !res_valid)
		else $error("result offered while taking a new voxel");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.empty_res |-> res.last && res.weight == '0)
		else $error("empty result not final or carries a weight");

	a_row_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.empty_res |-> res.row_index >= res.first_row
			&& res.row_count != '0)
		else $error("row outside its run");

	a_row_step: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall && !res.last |=> !res_valid)
		else $error("next row offered without being computed");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the cone-beam axial weight generator.
`timescale 1ns / 1ps

module testbench;

	localparam int MaxRows    = cbaw_pkg::MaxRowsDef;
	localparam int MaxRun     = cbaw_pkg::MaxRunDef;
	localparam int IdleLimit  = 5000;  // cycles with no transfer before giving up
	localparam int SettleCyc  = 8;
	localparam int Q1         = 65536;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           cfg_we = 1'b0;
	logic [2:0]     cfg_index = '0;
	logic [31:0]    cfg_data = '0;
	logic           vox_valid = 1'b0;
	logic           vox_stall;
	cbaw_pkg::vox_t vox = '0;
	logic           res_valid;
	logic           res_stall = 1'b0;
	cbaw_pkg::res_t res;

	// predictor copy of the register file
	longint          src_u, sdd, w_first;
	longint unsigned pitch_r, rows_r, thick_r, qinv_r;
	bit              quant_en;

	cbaw_pkg::res_t pending_rows[$];
	int   errors = 0;
	int   tx_idle_pct = 0;
	int   rx_stall_pct = 0;
	int   quiet_cycles = 0;

	cone_beam_axial_weight_gen_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.vox_valid(vox_valid),
		.vox_stall(vox_stall),
		.vox      (vox),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

	always #5 clk = ~clk;

	// receiver back-pressure, redrawn every cycle
	always @(posedge clk) begin
		res_stall <= ($urandom_range(99) < rx_stall_pct);
	end

	// floor division by 2^16
	function automatic longint floor_q16(longint x);
		if (x >= 0)
			return x >>> 16;
		return -(((-x) + 65535) >>> 16);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned acc = 0;
		longint unsigned bitv = 64'd1 << 62;
		while (bitv > n)
			bitv >>= 2;
		while (bitv != 0) begin
			if (n >= acc + bitv) begin
				n -= acc + bitv;
				acc = (acc >> 1) + bitv;
			end else begin
				acc >>= 1;
			end
			bitv >>= 2;
		end
		return acc;
	endfunction

	// expected row weights for one accepted voxel
	function automatic void predict_weights(cbaw_pkg::vox_t v);
		longint vu, vw, du, p, rows, m, wp, mw, centre, base, first, stop, count;
		longint row, wd, d2, bb, l2;
		longint unsigned a, b, f, len, wt, prod, code;
		cbaw_pkg::res_t r;
		vu = v.voxel_u;
		vw = v.voxel_w;
		du = vu - src_u;
		p = (pitch_r == 0) ? 1 : longint'(pitch_r);
		rows = (rows_r > MaxRows) ? MaxRows : longint'(rows_r);
		r = '0;
		r.empty_res = 1'b1;
		r.last = 1'b1;
		if (du == 0) begin
			pending_rows.push_back(r);
			return;
		end
		m = (sdd * 65536) / du;
		if (m > 64'sh7FFFFFFF)
			m = 64'sh7FFFFFFF;
		if (m < -64'sh80000000)
			m = -64'sh80000000;
		wp = floor_q16(m * longint'(thick_r));
		mw = floor_q16(m * vw);
		centre = w_first + (p >>> 1);
		base = mw - centre;
		first = (2 * base - wp + p) / (2 * p);
		stop = (2 * base + wp + p) / (2 * p);
		if (first < 0)
			first = 0;
		if (stop > rows - 1)
			stop = rows - 1;
		count = stop - first + 1;
		if (count <= 0) begin
			pending_rows.push_back(r);
			return;
		end
		if (count > MaxRun)
			count = MaxRun;
		// obliquity: scale both legs into 31 bits before the root
		a = (du < 0) ? -du : du;
		b = (vw < 0) ? -vw : vw;
		while (a >= 64'h80000000 || b >= 64'h80000000) begin
			a >>= 1;
			b >>= 1;
		end
		if (a == 0) begin
			f = 64'hFFFFFFFF;
		end else begin
			f = (int_sqrt(a * a + b * b) << 16) / a;
			if (f > 64'hFFFFFFFF)
				f = 64'hFFFFFFFF;
		end
		for (int k = 0; k < count; k++) begin
			row = first + k;
			wd = centre + row * p;
			d2 = 2 * ((wd - mw) < 0 ? mw - wd : wd - mw);
			bb = (wp - p) < 0 ? p - wp : wp - p;
			l2 = (wp + p) - (bb > d2 ? bb : d2);
			len = (l2 > 0) ? longint'(l2) >> 1 : 0;
			if (len > p)
				len = p;
			wt = (len * f) / longint'(p);
			if (wt > 64'hFFFFFFFF)
				wt = 64'hFFFFFFFF;
			if (quant_en) begin
				prod = wt * qinv_r;
				code = (prod >> 32) + ((prod >> 31) & 1);
				wt = (code > 255) ? 255 : code;
			end
			r.first_row = first[11:0];
			r.row_count = count[6:0];
			r.row_index = row[11:0];
			r.weight = wt[31:0];
			r.empty_res = 1'b0;
			r.last = (k == count - 1);
			pending_rows.push_back(r);
		end
	endfunction

	task automatic report_field(string name, longint unsigned exp_v, longint unsigned got_v);
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
		errors++;
	endtask

	// result checker and watchdog
	always @(posedge clk) begin
		cbaw_pkg::res_t exp_r;
		if ((vox_valid && !vox_stall) || (res_valid && !res_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IdleLimit) begin
			$display("%0t: watchdog expired", $time);
			$display("status: fail");
			$finish;
		end
		if (arst_n && res_valid && !res_stall) begin
			if (pending_rows.size() == 0) begin
				$display("%0t: unexpected result transfer, actual %p", $time, res);
				errors++;
			end else begin
				exp_r = pending_rows.pop_front();
				if (res.first_row !== exp_r.first_row)
					report_field("first_row", exp_r.first_row, res.first_row);
				if (res.row_count !== exp_r.row_count)
					report_field("row_count", exp_r.row_count, res.row_count);
				if (res.row_index !== exp_r.row_index)
					report_field("row_index", exp_r.row_index, res.row_index);
				if (res.weight !== exp_r.weight)
					report_field("weight", exp_r.weight, res.weight);
				if (res.empty_res !== exp_r.empty_res)
					report_field("empty_res", exp_r.empty_res, res.empty_res);
				if (res.last !== exp_r.last)
					report_field("last", exp_r.last, res.last);
			end
		end
	end

	// leaves cfg_we high; set_geometry lowers it once after the last write
	task automatic write_reg(cbaw_pkg::cfg_reg_t idx, logic [31:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		case (idx)
			cbaw_pkg::REG_SOURCE_U:  src_u = longint'($signed(d));
			cbaw_pkg::REG_SDD:       sdd = longint'($signed(d));
			cbaw_pkg::REG_W_FIRST:   w_first = longint'($signed(d));
			cbaw_pkg::REG_PITCH:     pitch_r = d[30:0];
			cbaw_pkg::REG_ROWS:      rows_r = d[12:0];
			cbaw_pkg::REG_THICK:     thick_r = d[30:0];
			cbaw_pkg::REG_QUANT_INV: qinv_r = d;
			cbaw_pkg::REG_QUANT_EN:  quant_en = d[0];
			default: ;
		endcase
	endtask

	task automatic set_geometry(int su, int sd, int wf, int pt, int nr, int th,
			int qi, bit qe);
		write_reg(cbaw_pkg::REG_SOURCE_U, su);
		write_reg(cbaw_pkg::REG_SDD, sd);
		write_reg(cbaw_pkg::REG_W_FIRST, wf);
		write_reg(cbaw_pkg::REG_PITCH, pt);
		write_reg(cbaw_pkg::REG_ROWS, nr);
		write_reg(cbaw_pkg::REG_THICK, th);
		write_reg(cbaw_pkg::REG_QUANT_INV, qi);
		write_reg(cbaw_pkg::REG_QUANT_EN, qe);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// one voxel transfer; valid stays high on return so the caller decides
	task automatic send_voxel(int vu, int vw);
		while ($urandom_range(99) < tx_idle_pct) begin
			vox_valid <= 1'b0;
			@(posedge clk);
		end
		vox_valid <= 1'b1;
		vox <= '{voxel_u: vu, voxel_w: vw};
		do
			@(posedge clk);
		while (vox_stall);
		predict_weights(vox);
	endtask

	task automatic drain_results();
		vox_valid <= 1'b0;
		while (pending_rows.size() != 0)
			@(posedge clk);
		repeat (SettleCyc) @(posedge clk);
	endtask

	// voxel in the field of view of the standard geometry
	task automatic send_fov_voxel();
		send_voxel($urandom_range(4 * Q1) - 2 * Q1, $urandom_range(10 * Q1) - 5 * Q1);
	endtask

	task automatic send_noise_voxel();
		send_voxel($urandom, $urandom);
	endtask

	task automatic standard_geometry(bit qe);
		set_geometry(-10 * Q1, 20 * Q1, -8 * Q1 + $urandom_range(Q1), Q1 + $urandom_range(Q1),
			16, Q1 / 2 + $urandom_range(Q1), 200 * Q1 + $urandom, qe);
	endtask

	task automatic test_reset_defaults();
		send_voxel(Q1, 0);
		send_voxel(0, 0);                     // source at voxel
		send_voxel(-Q1, Q1);                  // negative magnification
		send_voxel(32'h7FFFFFFF, 32'h80000000);
		send_voxel(32'h80000000, 32'h7FFFFFFF);
		drain_results();
	endtask

	task automatic test_directed_edges();
		standard_geometry(1'b0);
		send_voxel(int'(src_u), 0);           // source at voxel
		send_voxel(0, 0);
		send_voxel(0, 40 * Q1);               // above the detector, empty
		send_voxel(0, -40 * Q1);              // below, first row clamps at zero
		send_voxel(-20 * Q1, Q1);             // behind the source
		send_voxel(32'h7FFFFFFF, 32'h7FFFFFFF);
		send_voxel(32'h80000000, 32'h80000000);
		send_voxel(-10 * Q1 + 1, 0);          // magnification saturates
		drain_results();
		// thick voxel: run longer than the clip limit
		set_geometry(-10 * Q1, 20 * Q1, -100 * Q1, Q1, 4096, 90 * Q1, Q1, 1'b1);
		send_voxel(0, 0);
		send_voxel(Q1, Q1);
		drain_results();
	endtask

	task automatic test_register_extremes();
		// zero pitch, zero rows, oversized rows, extreme quantizer settings
		set_geometry(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 0, 8191, 32'h7FFFFFFF,
			32'hFFFFFFFF, 1'b1);
		repeat (4) send_noise_voxel();
		send_voxel(0, 0);
		drain_results();
		set_geometry(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 1, 0, 1'b1);
		repeat (4) send_noise_voxel();
		drain_results();
		set_geometry(0, -20 * Q1, 0, 1, 4096, 1, 32'hFFFFFFFF, 1'b0);
		repeat (4) send_noise_voxel();
		send_voxel(-Q1, 0);
		drain_results();
		set_geometry(-10 * Q1, 20 * Q1, -8 * Q1, Q1, 1, Q1, 0, 1'b1);
		repeat (4) send_fov_voxel();
		drain_results();
	endtask

	task automatic test_random_phase(int tx_pct, int rx_pct);
		tx_idle_pct = tx_pct;
		rx_stall_pct = rx_pct;
		for (int blk = 0; blk < 4; blk++) begin
			standard_geometry(blk[0]);
			for (int n = 0; n < 27; n++) begin
				if ($urandom_range(99) < 85)
					send_fov_voxel();
				else
					send_noise_voxel();
			end
			drain_results();
		end
	endtask

	initial begin
		src_u = 0;
		sdd = Q1;
		w_first = 0;
		pitch_r = Q1;
		rows_r = 1;
		thick_r = Q1;
		qinv_r = Q1;
		quant_en = 1'b1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_directed_edges();
		test_register_extremes();
		test_random_phase(14, 84);
		test_random_phase(84, 14);
		test_random_phase(0, 0);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
